@@ design/miu_pkg.sv @@
// Package: shared types and constants for the multicore interrupt unit
`timescale 1ns / 1ps
package miu_pkg;

    localparam int MaxCores = 16;
    localparam int DefCores = 12;
    localparam int LineW = 12;
    localparam int DataW = 64;
    localparam logic [3:0] ActiveReset = 4'd12;

    typedef enum logic [3:0] {
        OP_EN_WR    = 4'd0,
        OP_EN4_WR   = 4'd1,
        OP_MBOX_SET = 4'd2,
        OP_MBOX_CLR = 4'd3,
        OP_EN_W1C   = 4'd4,
        OP_EN4_W1C  = 4'd5,
        OP_EN_W1S   = 4'd6,
        OP_EN4_W1S  = 4'd7,
        OP_NMI      = 4'd8,
        OP_RAISE    = 4'd9,
        OP_LOWER    = 4'd10,
        OP_SOFT_RST = 4'd11,
        OP_R12      = 4'd12,
        OP_R13      = 4'd13,
        OP_R14      = 4'd14,
        OP_R15      = 4'd15
    } op_t;

    typedef struct packed {
        logic [3:0]       opcode;
        logic [3:0]       core;
        logic             line;
        logic             upper_word;
        logic [DataW-1:0] data;
        logic [5:0]       source_bit;
    } req_t;

    typedef struct packed {
        logic [LineW-1:0] ip2_lines;
        logic [LineW-1:0] ip3_lines;
        logic [LineW-1:0] ip4_lines;
        logic [LineW-1:0] nmi_pulse;
        logic             reset_request;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_REPORT
    } state_t;

    // controller commands to the datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic report;
    } cmd_t;

endpackage

@@ design/miu_ctrl.sv @@
// Controller: sequences capture, update and report of one transaction
`timescale 1ns / 1ps
module miu_ctrl
    import miu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_REPORT;
            ST_REPORT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_UPDATE: cmd.update = 1'b1;
            ST_REPORT: cmd.report = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

endmodule

@@ design/miu_dp.sv @@
// Datapath: interrupt state registers, update logic and line reporting
`timescale 1ns / 1ps
module miu_dp
    import miu_pkg::*;
#(
    parameter int NUM_CORES = DefCores
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  req_t       req,
    input  logic [3:0] active_cores,
    output rsp_t       result,
    output logic       result_valid
);

    localparam int NE = 2 * NUM_CORES;
    localparam int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int EW = $clog2(NE);
    localparam int NL = (NUM_CORES < LineW) ? NUM_CORES : LineW;

    req_t req_reg;
    logic [DataW-1:0] sum_reg  [NE];
    logic [DataW-1:0] en_reg   [NE];
    logic [DataW-1:0] sum4_reg [NUM_CORES];
    logic [DataW-1:0] en4_reg  [NUM_CORES];
    logic [DataW-1:0] mbox_reg [NUM_CORES];
    rsp_t result_reg;
    rsp_t result_next;
    logic valid_reg;
    logic [LineW-1:0] nmi_reg;
    logic [LineW-1:0] nmi_next;
    logic rst_req_reg;
    logic rst_req_next;

    // capture request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req;
    end

    // decode
    logic            core_ok;
    logic [CW-1:0]   ci;
    logic [EW-1:0]   ei;
    logic [4:0]      live_n;
    logic [MaxCores-1:0] live_mask;
    logic [DataW-1:0] mbox_new;
    logic [1:0]      mbits;
    logic [DataW-1:0] flag;
    op_t             op;

    always_comb
    begin
        op       = op_t'(req_reg.opcode);
        core_ok  = {1'b0, req_reg.core} < 5'(NUM_CORES);
        ci       = CW'(req_reg.core);
        ei       = EW'({req_reg.core, req_reg.line});
        live_n   = ({1'b0, active_cores} > 5'(NUM_CORES)) ? 5'(NUM_CORES)
                                                          : {1'b0, active_cores};
        live_mask = MaxCores'((17'd1 << live_n) - 17'd1);
        flag     = DataW'(1) << req_reg.source_bit;
        mbox_new = (op == OP_MBOX_SET) ? req_reg.data
                                       : (mbox_reg[ci] & ~req_reg.data);
        mbits    = {|mbox_new[63:32], |mbox_new[31:0]};
        nmi_next = (op == OP_NMI) ? (req_reg.data[LineW-1:0] & live_mask[LineW-1:0])
                                  : '0;
        rst_req_next = (op == OP_SOFT_RST);
    end

    // per-transaction NMI pulse and reset request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nmi_reg     <= '0;
            rst_req_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            nmi_reg     <= nmi_next;
            rst_req_reg <= rst_req_next;
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NE; i++)
            begin
                sum_reg[i] <= '0;
                en_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_CORES; i++)
            begin
                sum4_reg[i] <= '0;
                en4_reg[i]  <= '0;
                mbox_reg[i] <= '0;
            end
        end
        else if (cmd.update)
        begin
            case (op) inside
                OP_EN_WR:  if (core_ok && !req_reg.upper_word) en_reg[ei] <= req_reg.data;
                OP_EN4_WR: if (core_ok && !req_reg.upper_word) en4_reg[ci] <= req_reg.data;
                OP_EN_W1C:
                    if (core_ok && !req_reg.upper_word) en_reg[ei] <= en_reg[ei] & ~req_reg.data;
                OP_EN4_W1C:
                    if (core_ok && !req_reg.upper_word)
                        en4_reg[ci] <= en4_reg[ci] & ~req_reg.data;
                OP_EN_W1S:
                    if (core_ok && !req_reg.upper_word) en_reg[ei] <= en_reg[ei] | req_reg.data;
                OP_EN4_W1S:
                    if (core_ok && !req_reg.upper_word)
                        en4_reg[ci] <= en4_reg[ci] | req_reg.data;
                OP_MBOX_SET, OP_MBOX_CLR:
                    if (core_ok)
                    begin
                        mbox_reg[ci] <= mbox_new;
                        sum_reg[{ci, 1'b0}] <= {sum_reg[{ci, 1'b0}][63:2], mbits};
                        sum_reg[{ci, 1'b1}] <= {sum_reg[{ci, 1'b1}][63:2], mbits};
                        sum4_reg[ci] <= {sum4_reg[ci][63:2], mbits};
                    end
                OP_RAISE, OP_LOWER:
                    for (int c = 0; c < NUM_CORES; c++)
                    begin
                        if (live_mask[c])
                        begin
                            if (op == OP_RAISE)
                            begin
                                sum_reg[2*c]   <= sum_reg[2*c] | flag;
                                sum_reg[2*c+1] <= sum_reg[2*c+1] | flag;
                                sum4_reg[c]    <= sum4_reg[c] | flag;
                            end
                            else
                            begin
                                sum_reg[2*c]   <= sum_reg[2*c] & ~flag;
                                sum_reg[2*c+1] <= sum_reg[2*c+1] & ~flag;
                                sum4_reg[c]    <= sum4_reg[c] & ~flag;
                            end
                        end
                    end
                default: ;
            endcase
        end
    end

    // line vectors from updated state
    always_comb
    begin
        result_next = '0;
        for (int k = 0; k < NL; k++)
        begin
            result_next.ip2_lines[k] = |(sum_reg[2*k] & en_reg[2*k]);
            result_next.ip3_lines[k] = |(sum_reg[2*k+1] & en_reg[2*k+1]);
            result_next.ip4_lines[k] = |(sum4_reg[k] & en4_reg[k]);
        end
        result_next.nmi_pulse     = nmi_reg;
        result_next.reset_request = rst_req_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.report;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
            result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

@@ design/multicore_interrupt_unit_top.sv @@
// Top level of the multicore interrupt unit
//  channel   | signals                      | transfer rule
//  request   | start, busy, req             | start && !busy
//  result    | done, result                 | done high for one cycle
//  config    | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
// Each transaction runs from the accepting edge through state update and line
// reduction into the output register, then done is high for one cycle. The
// request port takes no new transaction while busy, until the controller has
// stepped through its three states back to idle.
// Reset clears all interrupt state and sets active_cores to 12.
// Results cannot be stalled; done pulses once per transaction.
`timescale 1ns / 1ps
module multicore_interrupt_unit_top
    import miu_pkg::*;
#(
    parameter int NUM_CORES = DefCores
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       req,
    output logic       done,
    output rsp_t       result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);

    cmd_t cmd;
    logic [3:0] active_reg;

    // active core count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= ActiveReset;
        else if (cfg_valid && cfg_ready)
            active_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;

    miu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    miu_dp #(.NUM_CORES(NUM_CORES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req          (req),
        .active_cores (active_reg),
        .result       (result),
        .result_valid (done)
    );

endmodule
